// ===== hdl/f32t_pkg.sv =====
package f32t_pkg;

    // Pipeline depths and the sum window width
    localparam int FMA_LAT   = 7;
    localparam int DIV_STEPS = 27;
    localparam int DIV_LAT   = DIV_STEPS + 4;
    localparam int OUT_STG   = 9 * FMA_LAT + DIV_LAT + 1;
    localparam int WIN       = 79;

    // Binary32 constants
    localparam logic [31:0] K_CUT       = 32'hC110_2CB4;
    localparam logic [31:0] K_BIAS      = 32'h4940_0000;
    localparam logic [31:0] K_NEG_BIAS  = 32'hC940_0000;
    localparam logic [31:0] K_LOG2E     = 32'h3FB8_AA3B;
    localparam logic [31:0] K_MINUS_LN2 = 32'hBF31_7218;
    localparam logic [31:0] K_C4        = 32'h3EAA_AC76;
    localparam logic [31:0] K_C3        = 32'h3F2A_AE10;
    localparam logic [31:0] K_ONE       = 32'h3F80_0000;
    localparam logic [31:0] K_NEG_ONE   = 32'hBF80_0000;
    localparam logic [31:0] K_TWO       = 32'h4000_0000;
    localparam logic [31:0] K_NEG_ZERO  = 32'h8000_0000;
    localparam logic [31:0] K_QUIET     = 32'h0040_0000;

    typedef logic signed [12:0] t_exp;

    // Unpacked operand: value = m * 2^e
    typedef struct packed {
        logic       s;
        t_exp       e;
        logic [23:0] m;
    } t_unp;

    // Exact sum ahead of rounding: value = mag * 2^base
    typedef struct packed {
        logic          s;
        logic          zs;
        t_exp          base;
        logic [WIN-1:0] mag;
    } t_sum;

    typedef struct packed {
        logic          s;
        logic          zs;
        logic          zero;
        t_exp          sh;
        logic [7:0]    fexp;
        logic [WIN-1:0] mag;
    } t_nrm;

    typedef struct packed {
        logic          s;
        logic          zs;
        logic          zero;
        logic [7:0]    fexp;
        logic [WIN-1:0] mag;
        logic          st;
    } t_shf;

    // exp2(k/8) table, each entry less (k << 20)
    function automatic logic [31:0] f_exp2_tab(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h3F80_0000;
            3'd1: v = 32'h3F7B_95C2;
            3'd2: v = 32'h3F78_37F0;
            3'd3: v = 32'h3F75_FED7;
            3'd4: v = 32'h3F75_04F3;
            3'd5: v = 32'h3F75_672A;
            3'd6: v = 32'h3F77_44FD;
            3'd7: v = 32'h3F7A_C0C7;
            default: v = 32'h3F80_0000;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] f_lzc24(input logic [23:0] v);
        logic [4:0] lz;
        logic       found;
        lz    = '0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                lz    = 5'(23 - i);
                found = 1'b1;
            end
        end
        return lz;
    endfunction

    function automatic logic [6:0] f_lzc79(input logic [WIN-1:0] v);
        logic [6:0] lz;
        logic       found;
        lz    = '0;
        found = 1'b0;
        for (int i = WIN - 1; i >= 0; i--) begin
            if (!found && v[i]) begin
                lz    = 7'(WIN - 1 - i);
                found = 1'b1;
            end
        end
        return lz;
    endfunction

    // Unpack a finite binary32; when norm is set, move the leading one to bit 23
    function automatic t_unp f_unpack(input logic [31:0] x, input logic norm);
        t_unp       u;
        logic [7:0] f;
        logic [4:0] lz;
        f    = x[30:23];
        u.s  = x[31];
        u.m  = {(f != 8'd0), x[22:0]};
        u.e  = (f == 8'd0) ? -13'sd149 : ($signed({5'd0, f}) - 13'sd150);
        lz   = f_lzc24(u.m);
        if (norm) begin
            u.m = u.m << lz;
            u.e = $signed(u.e) - $signed({8'd0, lz});
        end
        return u;
    endfunction

    // Find the leading one and the shift that lands the result LSB
    function automatic t_nrm f_norm(input t_sum a);
        t_nrm       r;
        logic [6:0] lz;
        t_exp       ex;
        t_exp       dn;
        lz     = f_lzc79(a.mag);
        ex     = $signed(a.base) + 13'sd78 - $signed({6'd0, lz});
        r.s    = a.s;
        r.zs   = a.zs;
        r.zero = (a.mag == '0);
        r.mag  = a.mag;
        if (ex < -13'sd126) begin
            dn     = -13'sd126 - ex;
            r.fexp = 8'd0;
        end else begin
            dn     = '0;
            r.fexp = 8'(ex + 13'sd126);
        end
        r.sh = $signed({6'd0, lz}) - dn;
        return r;
    endfunction

    // Shift left to normalize, or right with sticky for tiny results
    function automatic t_shf f_shift(input t_nrm a);
        t_shf           r;
        logic [6:0]     ra;
        logic [WIN-1:0] msk;
        r.s    = a.s;
        r.zs   = a.zs;
        r.zero = a.zero;
        r.fexp = a.fexp;
        ra     = 7'(-$signed(a.sh));
        msk    = ~({WIN{1'b1}} << ra);
        if ($signed(a.sh) >= 13'sd0) begin
            r.mag = a.mag << a.sh[6:0];
            r.st  = 1'b0;
        end else if ($signed(a.sh) < -13'sd78) begin
            r.mag = '0;
            r.st  = |a.mag;
        end else begin
            r.mag = a.mag >> ra;
            r.st  = |(a.mag & msk);
        end
        return r;
    endfunction

    // Round to nearest even and pack
    function automatic logic [31:0] f_pack(input t_shf a);
        logic [23:0] m;
        logic        g;
        logic        st;
        logic        up;
        logic [30:0] mag;
        m   = a.mag[WIN-1:WIN-24];
        g   = a.mag[WIN-25];
        st  = (|a.mag[WIN-26:0]) | a.st;
        up  = g & (st | m[0]);
        mag = {a.fexp, 23'd0} + {7'd0, m} + {30'd0, up};
        return a.zero ? {a.zs, 31'd0} : {a.s, mag};
    endfunction

endpackage

// ===== hdl/f32t_fma.sv =====
module f32t_fma import f32t_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [31:0] o_r
);

    t_unp           r1_ua, r1_ub, r1_uc;
    logic           r2_sp;
    t_exp           r2_ep;
    logic [47:0]    r2_p;
    t_unp           r2_uc;
    logic           r3_sp, r3_sc, r3_zs;
    t_exp           r3_base;
    logic [WIN-1:0] r3_pw, r3_cw;
    t_sum           r4_sum;
    t_nrm           r5_nrm;
    t_shf           r6_shf;
    logic [31:0]    r7_res;

    t_exp           d, k, rr;
    logic [4:0]     ra;
    logic [WIN-1:0] n_pw, n_cw;
    t_exp           n_base;
    logic [WIN:0]   diff;
    t_sum           n_sum;

    // Align the addend against the product window
    always_comb begin
        d      = r2_uc.e - r2_ep;
        k      = d + 13'sd3;
        rr     = 13'sd1 - k;
        ra     = rr[4:0];
        n_pw   = WIN'(r2_p) << 3;
        n_base = r2_ep - 13'sd3;
        n_cw   = '0;
        if (r2_uc.m == 24'd0) begin
            n_cw = '0;
        end else if (k > 13'sd54) begin
            n_cw   = WIN'(r2_uc.m) << 54;
            n_pw   = WIN'(r2_p != 48'd0);
            n_base = r2_uc.e - 13'sd54;
        end else if (k >= 13'sd1) begin
            n_cw = WIN'(r2_uc.m) << k[5:0];
        end else if (rr >= 13'sd24) begin
            n_cw = WIN'(1'b1);
        end else begin
            n_cw = (WIN'(r2_uc.m >> ra) << 1)
                 | WIN'(|(r2_uc.m & ~(24'hFF_FFFF << ra)));
        end
    end

    // Add or subtract magnitudes
    always_comb begin
        diff       = {1'b0, r3_pw} - {1'b0, r3_cw};
        n_sum.zs   = r3_zs;
        n_sum.base = r3_base;
        if (r3_sp == r3_sc) begin
            n_sum.s   = r3_sp;
            n_sum.mag = r3_pw + r3_cw;
        end else if (diff[WIN]) begin
            n_sum.s   = r3_sc;
            n_sum.mag = WIN'(-diff);
        end else begin
            n_sum.s   = r3_sp;
            n_sum.mag = diff[WIN-1:0];
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ua   <= f_unpack(i_a, 1'b1);
            r1_ub   <= f_unpack(i_b, 1'b1);
            r1_uc   <= f_unpack(i_c, 1'b0);
            r2_sp   <= r1_ua.s ^ r1_ub.s;
            r2_ep   <= r1_ua.e + r1_ub.e;
            r2_p    <= r1_ua.m * r1_ub.m;
            r2_uc   <= r1_uc;
            r3_sp   <= r2_sp;
            r3_sc   <= r2_uc.s;
            r3_zs   <= (r2_p == 48'd0) & (r2_uc.m == 24'd0) & r2_sp & r2_uc.s;
            r3_base <= n_base;
            r3_pw   <= n_pw;
            r3_cw   <= n_cw;
            r4_sum  <= n_sum;
            r5_nrm  <= f_norm(r4_sum);
            r6_shf  <= f_shift(r5_nrm);
            r7_res  <= f_pack(r6_shf);
        end
    end

    assign o_r = r7_res;

endmodule

// ===== hdl/f32t_div.sv =====
module f32t_div import f32t_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_q
);

    logic [24:0]          r_rem  [0:DIV_STEPS];
    logic [23:0]          r_mb   [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_q    [0:DIV_STEPS];
    logic                 r_s    [0:DIV_STEPS];
    t_exp                 r_base [0:DIV_STEPS];
    t_nrm                 r_nrm;
    t_shf                 r_shf;
    logic [31:0]          r_res;

    t_unp ua, ub;
    t_sum n_sum;

    always_comb begin
        ua         = f_unpack(i_a, 1'b1);
        ub         = f_unpack(i_b, 1'b1);
        n_sum.s    = r_s[DIV_STEPS];
        n_sum.zs   = r_s[DIV_STEPS];
        n_sum.base = r_base[DIV_STEPS];
        n_sum.mag  = WIN'({r_q[DIV_STEPS], |r_rem[DIV_STEPS]});
    end

    // One restoring quotient bit per stage, then normalize and round
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {1'b0, ua.m};
            r_mb[0]   <= ub.m;
            r_q[0]    <= '0;
            r_s[0]    <= ua.s ^ ub.s;
            r_base[0] <= ua.e - ub.e - 13'sd27;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                if (r_rem[k-1] >= {1'b0, r_mb[k-1]}) begin
                    r_rem[k] <= 25'(r_rem[k-1] - {1'b0, r_mb[k-1]}) << 1;
                    r_q[k]   <= {r_q[k-1][DIV_STEPS-2:0], 1'b1};
                end else begin
                    r_rem[k] <= r_rem[k-1] << 1;
                    r_q[k]   <= {r_q[k-1][DIV_STEPS-2:0], 1'b0};
                end
                r_mb[k]   <= r_mb[k-1];
                r_s[k]    <= r_s[k-1];
                r_base[k] <= r_base[k-1];
            end
            r_nrm <= f_norm(n_sum);
            r_shf <= f_shift(r_nrm);
            r_res <= f_pack(r_shf);
        end
    end

    assign o_q = r_res;

endmodule

// ===== hdl/float32_tanh_unit.sv =====
// Hyperbolic tangent of IEEE binary32 values, one value per transaction.
// Input channel: i_valid / o_ready carry i_x_bits and i_in_last.
// Output channel: o_valid / i_ready carry o_y_bits and o_out_last.
// Each input transaction yields exactly one output transaction, in order;
// o_out_last repeats the in_last flag of the same value.
// Throughput: one value per clock while the receiver takes results.
// Path from input acceptance to o_valid: the input register, nine
// chained fused multiply-add units of 7 stages each, a 31-stage
// restoring divider, and the output register.
// NaN inputs come back quiet with sign and payload kept.
// Reset (i_rst_n low, synchronous) drops all transactions in flight;
// no clearing pass is needed, input is accepted right after reset.
// When the receiver holds i_ready low with a result waiting, the whole
// pipeline freezes and o_ready falls; nothing is lost or repeated.
module float32_tanh_unit import f32t_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_x_bits,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_y_bits,
    output logic        o_out_last
);

    logic                 en;
    logic [OUT_STG:0]     r_vld;
    logic [31:0]          r_xd   [0:OUT_STG-1];
    logic [OUT_STG-1:0]   r_ld;
    logic [31:0]          r_zd   [0:2*FMA_LAT-1];
    logic [31:0]          r_sd   [0:2*FMA_LAT-1];
    logic [31:0]          r_td   [0:2*FMA_LAT-1];
    logic [31:0]          r_tsd  [0:2*FMA_LAT-1];
    logic [31:0]          r_smd  [0:3*FMA_LAT-1];
    logic [31:0]          r_emd  [0:FMA_LAT-1];
    logic [31:0]          r_y;
    logic                 r_last;

    logic [31:0] zb, z0, sb;
    logic [31:0] w_n, w_nm, w_t, w_p1, w_ts, w_sm, w_p2, w_p3, w_p4;
    logic [31:0] w_em1, w_ep1, w_q, xo;
    logic        x_nan;

    // Global advance: move when the output slot is free or being taken
    assign en      = !r_vld[OUT_STG] || i_ready;
    assign o_ready = en;

    // Fold to the negative half-line and clamp; build the scale factor from w_n
    always_comb begin
        zb = r_xd[0] | K_NEG_ZERO;
        z0 = (zb[30:0] > K_CUT[30:0]) ? K_CUT : zb;
        sb = f_exp2_tab(w_n[2:0]) + {w_n[11:0], 20'd0};
    end

    f32t_fma u_fma_n   (.i_clk, .i_en(en), .i_a(z0),     .i_b(K_LOG2E),
                        .i_c(K_BIAS),           .o_r(w_n));
    f32t_fma u_fma_nm  (.i_clk, .i_en(en), .i_a(w_n),    .i_b(K_ONE),
                        .i_c(K_NEG_BIAS),       .o_r(w_nm));
    f32t_fma u_fma_t   (.i_clk, .i_en(en), .i_a(w_nm),   .i_b(K_MINUS_LN2),
                        .i_c(r_zd[2*FMA_LAT-1]), .o_r(w_t));
    f32t_fma u_fma_p1  (.i_clk, .i_en(en), .i_a(K_C4),   .i_b(w_t),
                        .i_c(K_C3),             .o_r(w_p1));
    f32t_fma u_fma_ts  (.i_clk, .i_en(en), .i_a(w_t),    .i_b(r_sd[2*FMA_LAT-1]),
                        .i_c(K_NEG_ZERO),       .o_r(w_ts));
    f32t_fma u_fma_sm  (.i_clk, .i_en(en), .i_a(r_sd[2*FMA_LAT-1]), .i_b(K_ONE),
                        .i_c(K_NEG_ONE),        .o_r(w_sm));
    f32t_fma u_fma_p2  (.i_clk, .i_en(en), .i_a(w_p1),   .i_b(r_td[FMA_LAT-1]),
                        .i_c(K_ONE),            .o_r(w_p2));
    f32t_fma u_fma_p3  (.i_clk, .i_en(en), .i_a(w_p2),   .i_b(r_td[2*FMA_LAT-1]),
                        .i_c(K_NEG_ZERO),       .o_r(w_p3));
    f32t_fma u_fma_p4  (.i_clk, .i_en(en), .i_a(w_p3),   .i_b(r_tsd[2*FMA_LAT-1]),
                        .i_c(r_tsd[2*FMA_LAT-1]), .o_r(w_p4));
    f32t_fma u_fma_em1 (.i_clk, .i_en(en), .i_a(w_p4),   .i_b(K_TWO),
                        .i_c(r_smd[3*FMA_LAT-1]), .o_r(w_em1));
    f32t_fma u_fma_ep1 (.i_clk, .i_en(en), .i_a(w_em1),  .i_b(K_ONE),
                        .i_c(K_TWO),            .o_r(w_ep1));

    f32t_div u_div (.i_clk, .i_en(en), .i_a(r_emd[FMA_LAT-1]), .i_b(w_ep1), .o_q(w_q));

    assign xo    = r_xd[OUT_STG-1];
    assign x_nan = (xo[30:23] == 8'hFF) && (xo[22:0] != 23'd0);

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[OUT_STG-1:0], i_valid};
        end
    end

    // Hold operands for later stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xd[0]  <= i_x_bits;
            r_ld     <= {r_ld[OUT_STG-2:0], i_in_last};
            r_zd[0]  <= z0;
            r_sd[0]  <= sb;
            r_td[0]  <= w_t;
            r_tsd[0] <= w_ts;
            r_smd[0] <= w_sm;
            r_emd[0] <= w_em1;
            for (int k = 1; k < OUT_STG; k++) r_xd[k] <= r_xd[k-1];
            for (int k = 1; k < 2*FMA_LAT; k++) begin
                r_zd[k]  <= r_zd[k-1];
                r_sd[k]  <= r_sd[k-1];
                r_td[k]  <= r_td[k-1];
                r_tsd[k] <= r_tsd[k-1];
            end
            for (int k = 1; k < 3*FMA_LAT; k++) r_smd[k] <= r_smd[k-1];
            for (int k = 1; k < FMA_LAT; k++) r_emd[k] <= r_emd[k-1];
            r_y    <= x_nan ? (xo | K_QUIET) : (w_q ^ {~xo[31], 31'd0});
            r_last <= r_ld[OUT_STG-1];
        end
    end

    assign o_valid    = r_vld[OUT_STG];
    assign o_y_bits   = r_y;
    assign o_out_last = r_last;

`ifndef ASSERT_OFF
    a_no_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_y_bits[30:23] == 8'hFF && o_y_bits[22:0] == 23'd0))
        else $error("infinite result");
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_y_bits[30:23] != 8'hFF) |-> (o_y_bits[30:0] <= 31'h3F80_0000))
        else $error("result magnitude above one");
    a_rst_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule
